// File: hw/rtl/vse_pkg.sv
// shared types and constants for the vortex sheet step block
`timescale 1ns / 1ps
`default_nettype none

package vse_pkg;

    localparam int POS_W   = 28;
    localparam int IDX_W   = 9;
    localparam int FUNC_W  = 2;
    localparam int NUM_W   = 58;
    localparam int DEN_W   = 48;
    localparam int PADDR_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP  = 2'd3;

    localparam logic [2:0] REG_N_POINTS     = 3'd0;
    localparam logic [2:0] REG_GAMMA        = 3'd1;
    localparam logic [2:0] REG_BLOB_SQ      = 3'd2;
    localparam logic [2:0] REG_PERIOD_WIDTH = 3'd3;
    localparam logic [2:0] REG_MID_ROW      = 3'd4;
    localparam logic [2:0] REG_PULL_RATE    = 3'd5;
    localparam logic [2:0] REG_STEP_H       = 3'd6;
    localparam logic [2:0] REG_SPREAD_LIMIT = 3'd7;

    typedef struct packed {
        logic [9:0]  n_points;
        logic [26:0] gamma;
        logic [26:0] blob_sq;
        logic [26:0] period_width;
        logic [26:0] mid_row;
        logic [19:0] pull_rate;
        logic [16:0] step_h;
        logic [26:0] spread_limit;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/vse_cfg.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module vse_cfg (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [vse_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output vse_pkg::t_cfg               o_cfg
);

    vse_pkg::t_cfg r_cfg;
    logic [2:0]    reg_sel;
    logic          wr_en;

    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.n_points     <= 10'd260;
            r_cfg.gamma        <= 27'd38515;
            r_cfg.blob_sq      <= 27'd94372;
            r_cfg.period_width <= 27'd5242880;
            r_cfg.mid_row      <= 27'd786432;
            r_cfg.pull_rate    <= 20'd26214;
            r_cfg.step_h       <= 17'd546;
            r_cfg.spread_limit <= 27'd1415578;
        end else if (wr_en) begin
            unique case (reg_sel)
                vse_pkg::REG_N_POINTS:     r_cfg.n_points     <= pwdata[9:0];
                vse_pkg::REG_GAMMA:        r_cfg.gamma        <= pwdata[26:0];
                vse_pkg::REG_BLOB_SQ:      r_cfg.blob_sq      <= pwdata[26:0];
                vse_pkg::REG_PERIOD_WIDTH: r_cfg.period_width <= pwdata[26:0];
                vse_pkg::REG_MID_ROW:      r_cfg.mid_row      <= pwdata[26:0];
                vse_pkg::REG_PULL_RATE:    r_cfg.pull_rate    <= pwdata[19:0];
                vse_pkg::REG_STEP_H:       r_cfg.step_h       <= pwdata[16:0];
                vse_pkg::REG_SPREAD_LIMIT: r_cfg.spread_limit <= pwdata[26:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            vse_pkg::REG_N_POINTS:     prdata = {22'd0, r_cfg.n_points};
            vse_pkg::REG_GAMMA:        prdata = {5'd0, r_cfg.gamma};
            vse_pkg::REG_BLOB_SQ:      prdata = {5'd0, r_cfg.blob_sq};
            vse_pkg::REG_PERIOD_WIDTH: prdata = {5'd0, r_cfg.period_width};
            vse_pkg::REG_MID_ROW:      prdata = {5'd0, r_cfg.mid_row};
            vse_pkg::REG_PULL_RATE:    prdata = {12'd0, r_cfg.pull_rate};
            vse_pkg::REG_STEP_H:       prdata = {15'd0, r_cfg.step_h};
            vse_pkg::REG_SPREAD_LIMIT: prdata = {5'd0, r_cfg.spread_limit};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/vse_div.sv
// two-lane restoring divider, one quotient bit per cycle, shared divisor
`timescale 1ns / 1ps
`default_nettype none

module vse_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [vse_pkg::NUM_W-1:0]  i_num_a,
    input  wire  [vse_pkg::NUM_W-1:0]  i_num_b,
    input  wire  [vse_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [vse_pkg::NUM_W-1:0]  o_quo_a,
    output logic [vse_pkg::NUM_W-1:0]  o_quo_b,
    output logic [vse_pkg::DEN_W-1:0]  o_rem_a
);

    localparam int NW = vse_pkg::NUM_W;
    localparam int DW = vse_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_na, r_nb;
    logic [DW-1:0] r_ra, r_rb, r_den;

    logic [DW:0]   sh_a, sh_b, dif_a, dif_b;
    logic          ge_a, ge_b;

    assign sh_a  = {r_ra, r_na[NW-1]};
    assign sh_b  = {r_rb, r_nb[NW-1]};
    assign dif_a = sh_a - {1'b0, r_den};
    assign dif_b = sh_b - {1'b0, r_den};
    assign ge_a  = sh_a >= {1'b0, r_den};
    assign ge_b  = sh_b >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the numerator registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_na  <= i_num_a;
            r_nb  <= i_num_b;
            r_ra  <= '0;
            r_rb  <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_na <= {r_na[NW-2:0], ge_a};
            r_nb <= {r_nb[NW-2:0], ge_b};
            r_ra <= ge_a ? dif_a[DW-1:0] : sh_a[DW-1:0];
            r_rb <= ge_b ? dif_b[DW-1:0] : sh_b[DW-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_quo_a = r_na;
    assign o_quo_b = r_nb;
    assign o_rem_a = r_ra;

endmodule

`default_nettype wire

// File: hw/rtl/vortex_sheet_euler_step.sv
// Periodic point-vortex sheet: position store, pairwise velocity sum and Euler update.
// Input channel (i_s_*): one item per handshake; tuser carries func (load, step, read,
// no operation), tdata carries point_index, load_x and load_y. Every item gives exactly
// one result on the output channel (o_m_*), held in an output register until taken;
// a new item is accepted once the previous result sits in that register.
// Load and no-operation items go from idle straight to the done state; a read passes
// through a read state first. A step runs two passes over the position memory: the
// velocity pass sends each image pair through a pair of multiply stages, then a
// squared-distance stage and, unless that distance is zero, the shared divider; in the
// move pass that divider wraps x into the period, or x saturates if the width is zero.
// The result of a step carries the spread flag. Velocities live in a second memory
// between the passes. Reset (synchronous, active low) restores the register defaults
// and empties the output register; the memories are not cleared and hold nothing valid
// until loaded. A stalled receiver holds the result; at most one further item is taken
// meanwhile. Configuration must be written through the apb-style port only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module vortex_sheet_euler_step #(
    parameter int MAX_POINTS   = 512,
    parameter int IMAGE_COPIES = 3
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    // [8:0] point_index, [36:9] load_x, [64:37] load_y, [71:65] zero
    input  wire  [71:0]                 i_s_tdata,
    // [1:0] func
    input  wire  [1:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    // [27:0] pos_x, [55:28] pos_y, [56] spread_flag, [63:57] zero
    output logic [63:0]                 o_m_tdata,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [vse_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int PW      = vse_pkg::POS_W;
    localparam int NW      = vse_pkg::NUM_W;
    localparam int DW      = vse_pkg::DEN_W;
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int KW      = (IMAGE_COPIES > 1) ? $clog2(IMAGE_COPIES) : 1;
    localparam int MLO_ABS = (IMAGE_COPIES - 1) / 2;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RD     = 5'd1;
    localparam logic [4:0] ST_DONE   = 5'd2;
    localparam logic [4:0] ST_VI_RD  = 5'd3;
    localparam logic [4:0] ST_VI_CAP = 5'd4;
    localparam logic [4:0] ST_VJ_CAP = 5'd5;
    localparam logic [4:0] ST_PAIR   = 5'd6;
    localparam logic [4:0] ST_MUL1   = 5'd7;
    localparam logic [4:0] ST_MUL2   = 5'd8;
    localparam logic [4:0] ST_R2     = 5'd9;
    localparam logic [4:0] ST_DIVS   = 5'd10;
    localparam logic [4:0] ST_DIVW   = 5'd11;
    localparam logic [4:0] ST_NEXT   = 5'd12;
    localparam logic [4:0] ST_MV_RD  = 5'd13;
    localparam logic [4:0] ST_MV_A   = 5'd14;
    localparam logic [4:0] ST_MV_B   = 5'd15;
    localparam logic [4:0] ST_MV_C   = 5'd16;
    localparam logic [4:0] ST_MV_D   = 5'd17;
    localparam logic [4:0] ST_MV_DIV = 5'd18;
    localparam logic [4:0] ST_MV_WR  = 5'd19;

    localparam logic signed [63:0] ACC_LIM = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] D_LIM   = 64'sh0000_2000_0000_0000;
    localparam logic signed [63:0] V_MAX   = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] V_MIN   = -64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] P_MAX   = 64'sh0000_0000_07ff_ffff;
    localparam logic signed [63:0] P_MIN   = -64'sh0000_0000_0800_0000;

    vse_pkg::t_cfg cfg;

    vse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // memories: positions {x, y} and velocities {vx, vy}
    logic [2*PW-1:0] mem_pos [MAX_POINTS];
    logic [63:0]     mem_vel [MAX_POINTS];
    logic [2*PW-1:0] r_pos_q;
    logic [63:0]     r_vel_q;

    logic              pos_we, pos_re, vel_we, vel_re;
    logic [ADDR_W-1:0] pos_waddr, pos_raddr, vel_addr;
    logic [2*PW-1:0]   pos_wdata;
    logic [63:0]       vel_wdata;

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            mem_pos[pos_waddr] <= pos_wdata;
        end
        if (pos_re) begin
            r_pos_q <= mem_pos[pos_raddr];
        end
        if (vel_we) begin
            mem_vel[vel_addr] <= vel_wdata;
        end
        if (vel_re) begin
            r_vel_q <= mem_vel[vel_addr];
        end
    end

    // divider
    logic          div_start, div_done;
    logic [NW-1:0] div_num_a, div_num_b, div_quo_a, div_quo_b;
    logic [DW-1:0] div_den, div_rem_a;

    vse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_a (div_num_a),
        .i_num_b (div_num_b),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo_a (div_quo_a),
        .o_quo_b (div_quo_b),
        .o_rem_a (div_rem_a)
    );

    // control and datapath registers
    logic [4:0]               r_state, n_state;
    logic [ADDR_W-1:0]        r_i, n_i, r_j, n_j;
    logic [KW-1:0]            r_k, n_k;
    logic signed [PW-1:0]     r_px, n_px, r_py, n_py, r_xj, n_xj, r_yj, n_yj;
    logic signed [31:0]       r_off, n_off, r_off_base, n_off_base;
    logic signed [31:0]       r_dx, n_dx;
    logic signed [PW:0]       r_dy, n_dy;
    logic [63:0]              r_sq_a, n_sq_a, r_sq_b, n_sq_b;
    logic signed [NW:0]       r_nx, n_nx, r_ny, n_ny;
    logic [DW-1:0]            r_r2, n_r2;
    logic signed [63:0]       r_au, n_au, r_av, n_av;
    logic signed [63:0]       r_t1, n_t1, r_t2, n_t2, r_t3, n_t3;
    logic signed [39:0]       r_xn, n_xn;
    logic signed [46:0]       r_d, n_d;
    logic signed [PW-1:0]     r_yn, n_yn, r_xw, n_xw;
    logic                     r_spread, n_spread;
    logic [PW-1:0]            r_res_x, n_res_x, r_res_y, n_res_y;
    logic                     r_res_f, n_res_f;
    logic                     r_out_valid, n_out_valid;
    logic [63:0]              r_out_data, n_out_data;

    // input fields
    logic [1:0]        in_func;
    logic [8:0]        in_idx;
    logic [PW-1:0]     in_x, in_y;
    logic              in_ok;
    logic [ADDR_W-1:0] in_addr;

    assign in_func = i_s_tuser;
    assign in_idx  = i_s_tdata[8:0];
    assign in_x    = i_s_tdata[36:9];
    assign in_y    = i_s_tdata[64:37];
    assign in_ok   = 32'(in_idx) < MAX_POINTS;
    assign in_addr = ADDR_W'(in_idx);

    logic [CNT_W-1:0]  n_use;
    logic [ADDR_W-1:0] n_last;
    logic [KW-1:0]     k_last;

    assign n_use  = (32'(cfg.n_points) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                     : CNT_W'(cfg.n_points);
    assign n_last = ADDR_W'(n_use - 1'b1);
    assign k_last = KW'(IMAGE_COPIES - 1);

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // scratch values
    logic signed [63:0] prod_a, prod_b, acc_u, acc_v, term, wide;
    logic [NW-1:0]      mag_nx, mag_ny;
    logic signed [29:0] ydiff, yoff;
    logic [29:0]        yabs;
    logic [DW-1:0]      wrap;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_px        = r_px;
        n_py        = r_py;
        n_xj        = r_xj;
        n_yj        = r_yj;
        n_off       = r_off;
        n_off_base  = r_off_base;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sq_a      = r_sq_a;
        n_sq_b      = r_sq_b;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_r2        = r_r2;
        n_au        = r_au;
        n_av        = r_av;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_t3        = r_t3;
        n_xn        = r_xn;
        n_d         = r_d;
        n_yn        = r_yn;
        n_xw        = r_xw;
        n_spread    = r_spread;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_f     = r_res_f;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;

        pos_we    = 1'b0;
        pos_waddr = r_i;
        pos_wdata = {r_xw, r_yn};
        pos_re    = 1'b0;
        pos_raddr = r_i;
        vel_we    = 1'b0;
        vel_re    = 1'b0;
        vel_addr  = r_i;
        vel_wdata = '0;
        div_start = 1'b0;
        div_num_a = '0;
        div_num_b = '0;
        div_den   = {{(DW-27){1'b0}}, cfg.period_width};

        prod_a = '0;
        prod_b = '0;
        acc_u  = '0;
        acc_v  = '0;
        term   = '0;
        wide   = '0;
        mag_nx = r_nx[NW] ? NW'(-r_nx) : NW'(r_nx);
        mag_ny = r_ny[NW] ? NW'(-r_ny) : NW'(r_ny);
        ydiff  = '0;
        yoff   = '0;
        yabs   = '0;
        wrap   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_res_x = '0;
                    n_res_y = '0;
                    n_res_f = 1'b0;
                    n_state = ST_DONE;
                    if (in_func == vse_pkg::FUNC_STEP) begin
                        n_spread   = 1'b0;
                        n_i        = '0;
                        n_off_base = -($signed(32'(MLO_ABS)) *
                                       $signed({5'd0, cfg.period_width}));
                        if (n_use != '0) begin
                            n_state = ST_VI_RD;
                        end
                    end else if (in_func == vse_pkg::FUNC_LOAD && in_ok) begin
                        pos_we    = 1'b1;
                        pos_waddr = in_addr;
                        pos_wdata = {in_x, in_y};
                        n_res_x   = in_x;
                        n_res_y   = in_y;
                    end else if (in_func == vse_pkg::FUNC_READ && in_ok) begin
                        pos_re    = 1'b1;
                        pos_raddr = in_addr;
                        n_state   = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_res_x = r_pos_q[2*PW-1:PW];
                n_res_y = r_pos_q[PW-1:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_res_f, r_res_y, r_res_x};
                    n_state     = ST_IDLE;
                end
            end
            ST_VI_RD: begin
                pos_re  = 1'b1;
                n_state = ST_VI_CAP;
            end
            ST_VI_CAP: begin
                n_px      = r_pos_q[2*PW-1:PW];
                n_py      = r_pos_q[PW-1:0];
                n_au      = '0;
                n_av      = '0;
                n_j       = '0;
                pos_re    = 1'b1;
                pos_raddr = '0;
                n_state   = ST_VJ_CAP;
            end
            ST_VJ_CAP: begin
                n_xj    = r_pos_q[2*PW-1:PW];
                n_yj    = r_pos_q[PW-1:0];
                n_k     = '0;
                n_off   = r_off_base;
                n_state = ST_PAIR;
            end
            ST_PAIR: begin
                n_dx    = 32'(r_px) - (32'(r_xj) + r_off);
                n_dy    = (PW+1)'(r_py) - (PW+1)'(r_yj);
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                prod_a  = r_dx * r_dx;
                prod_b  = r_dx * $signed({1'b0, cfg.gamma});
                n_sq_a  = prod_a;
                n_nx    = prod_b[NW:0];
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                prod_a  = r_dy * r_dy;
                prod_b  = r_dy * $signed({1'b0, cfg.gamma});
                n_sq_b  = prod_a;
                n_ny    = prod_b[NW:0];
                n_state = ST_R2;
            end
            ST_R2: begin
                wide    = $signed((r_sq_a + r_sq_b) >> 16);
                n_r2    = DW'(wide) + DW'(cfg.blob_sq);
                n_state = ST_DIVS;
            end
            ST_DIVS: begin
                // coincident points with no softening add nothing
                if (r_r2 == '0) begin
                    n_state = ST_NEXT;
                end else begin
                    div_start = 1'b1;
                    div_num_a = mag_ny;
                    div_num_b = mag_nx;
                    div_den   = r_r2;
                    n_state   = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (div_done) begin
                    term  = r_ny[NW] ? -$signed({6'd0, div_quo_a})
                                     : $signed({6'd0, div_quo_a});
                    acc_u = r_au - term;
                    term  = r_nx[NW] ? -$signed({6'd0, div_quo_b})
                                     : $signed({6'd0, div_quo_b});
                    acc_v = r_av + term;
                    n_au  = (acc_u > ACC_LIM) ? ACC_LIM :
                            ((acc_u < -ACC_LIM) ? -ACC_LIM : acc_u);
                    n_av  = (acc_v > ACC_LIM) ? ACC_LIM :
                            ((acc_v < -ACC_LIM) ? -ACC_LIM : acc_v);
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_k != k_last) begin
                    n_k     = r_k + 1'b1;
                    n_off   = r_off + $signed({5'd0, cfg.period_width});
                    n_state = ST_PAIR;
                end else if (r_j != n_last) begin
                    n_j       = r_j + 1'b1;
                    pos_re    = 1'b1;
                    pos_raddr = r_j + 1'b1;
                    n_state   = ST_VJ_CAP;
                end else begin
                    acc_u     = (r_au > V_MAX) ? V_MAX : ((r_au < V_MIN) ? V_MIN : r_au);
                    acc_v     = (r_av > V_MAX) ? V_MAX : ((r_av < V_MIN) ? V_MIN : r_av);
                    vel_we    = 1'b1;
                    vel_wdata = {acc_u[31:0], acc_v[31:0]};
                    if (r_i != n_last) begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_VI_RD;
                    end else begin
                        n_i     = '0;
                        n_state = ST_MV_RD;
                    end
                end
            end
            ST_MV_RD: begin
                pos_re  = 1'b1;
                vel_re  = 1'b1;
                n_state = ST_MV_A;
            end
            ST_MV_A: begin
                ydiff   = 30'($signed(r_pos_q[PW-1:0])) - $signed({3'd0, cfg.mid_row});
                n_t1    = $signed(r_vel_q[63:32]) * $signed({1'b0, cfg.step_h});
                n_t2    = ydiff * $signed({1'b0, cfg.pull_rate});
                n_state = ST_MV_B;
            end
            ST_MV_B: begin
                wide    = r_t1 >>> 16;
                n_xn    = 40'($signed(r_pos_q[2*PW-1:PW])) + wide[39:0];
                acc_v   = 64'($signed(r_vel_q[31:0])) - (r_t2 >>> 16);
                acc_v   = (acc_v > D_LIM) ? D_LIM : ((acc_v < -D_LIM) ? -D_LIM : acc_v);
                n_d     = acc_v[46:0];
                n_state = ST_MV_C;
            end
            ST_MV_C: begin
                n_t3    = r_d * $signed({1'b0, cfg.step_h});
                n_state = ST_MV_D;
            end
            ST_MV_D: begin
                wide = 64'($signed(r_pos_q[PW-1:0])) + (r_t3 >>> 16);
                wide = (wide > P_MAX) ? P_MAX : ((wide < P_MIN) ? P_MIN : wide);
                n_yn = wide[PW-1:0];
                if (cfg.period_width == '0) begin
                    // no period: saturate instead of wrapping
                    acc_u   = 64'(r_xn);
                    acc_u   = (acc_u > P_MAX) ? P_MAX : ((acc_u < P_MIN) ? P_MIN : acc_u);
                    n_xw    = acc_u[PW-1:0];
                    n_state = ST_MV_WR;
                end else begin
                    div_start = 1'b1;
                    div_num_a = r_xn[39] ? NW'(-r_xn) : NW'(r_xn);
                    n_state   = ST_MV_DIV;
                end
            end
            ST_MV_DIV: begin
                if (div_done) begin
                    wrap = (r_xn[39] && div_rem_a != '0)
                           ? DW'(cfg.period_width) - div_rem_a : div_rem_a;
                    n_xw    = wrap[PW-1:0];
                    n_state = ST_MV_WR;
                end
            end
            ST_MV_WR: begin
                pos_we = 1'b1;
                yoff   = 30'(r_yn) - $signed({3'd0, cfg.mid_row});
                yabs   = yoff[29] ? 30'(-yoff) : 30'(yoff);
                if (yabs > {3'd0, cfg.spread_limit}) begin
                    n_spread = 1'b1;
                end
                if (r_i != n_last) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_MV_RD;
                end else begin
                    n_res_f = n_spread;
                    n_state = ST_DONE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_spread    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_spread    <= n_spread;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_xj       <= n_xj;
        r_yj       <= n_yj;
        r_off      <= n_off;
        r_off_base <= n_off_base;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_sq_a     <= n_sq_a;
        r_sq_b     <= n_sq_b;
        r_nx       <= n_nx;
        r_ny       <= n_ny;
        r_r2       <= n_r2;
        r_au       <= n_au;
        r_av       <= n_av;
        r_t1       <= n_t1;
        r_t2       <= n_t2;
        r_t3       <= n_t3;
        r_xn       <= n_xn;
        r_d        <= n_d;
        r_yn       <= n_yn;
        r_xw       <= n_xw;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        r_res_f    <= n_res_f;
        r_out_data <= n_out_data;
    end

    // velocity is written only once every source point and image is summed
    a_vel_after_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vel_we |-> (r_state == ST_NEXT && r_k == k_last && r_j == n_last))
        else $error("velocity written before the pair sum finished");

    // the divider never sees a zero divisor in the velocity pass
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_start && r_state == ST_DIVS) |-> (r_r2 != '0))
        else $error("divider started with zero squared distance");

    // a finished result is never dropped while the receiver stalls
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_m_tready) |=> (r_state == ST_DONE))
        else $error("result left the done state while output register was full");

    // positions are never rewritten while the velocity pass still reads them
    a_pos_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos_we |-> (r_state == ST_IDLE || r_state == ST_MV_WR))
        else $error("position memory written outside load or move");

endmodule

`default_nettype wire

// File: verif/tb_vortex_sheet_euler_step.sv
// testbench for the vortex sheet step block: stream driver, monitor and in-line position model
`timescale 1ns / 1ps

module tb_vortex_sheet_euler_step;

    localparam int  NPTS       = 512;
    localparam int  COPIES     = 3;
    localparam int  STEP_MAX_N = 8;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint POS_LO  = -(64'sd1 <<< 27);
    localparam longint POS_HI  = (64'sd1 <<< 27) - 1;
    localparam longint SUM_LIM = 64'sd1 <<< 62;
    localparam longint HOP_LIM = 64'sd1 <<< 45;

    typedef struct {
        logic [1:0]  op;
        logic [8:0]  idx;
        logic [27:0] lx;
        logic [27:0] ly;
    } t_vortex_item;

    typedef struct {
        logic [27:0] px;
        logic [27:0] py;
        logic        flag;
    } t_vortex_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [vse_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_tready, m_tvalid, pready;
    wire  [63:0] m_tdata;
    wire  [31:0] prdata;

    vortex_sheet_euler_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // model copy of the block state and registers
    longint cfg_n, cfg_gamma, cfg_blob, cfg_period, cfg_mid, cfg_rate, cfg_h, cfg_spread;
    longint mem_x[NPTS], mem_y[NPTS], vel_x[NPTS], vel_y[NPTS];
    bit     loaded[NPTS];
    int     loaded_list[$];

    t_vortex_item   pending_items[$];
    t_vortex_result expected_results[$];
    t_vortex_item   cur_item;
    int     fail_count = 0;
    int     send_gap = 0, recv_stall = 0;
    bit     quiet = 1'b0;
    longint cycle_count = 0;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void sum_velocity(int i, int n);
        longint au, av, dx, dy, r2, cx;
        longint mlo;
        logic [63:0] sq;
        au = 0;
        av = 0;
        mlo = -((COPIES - 1) / 2);
        for (int j = 0; j < n; j++) begin
            for (int k = 0; k < COPIES; k++) begin
                cx = mem_x[j] + (mlo + k) * cfg_period;
                dx = mem_x[i] - cx;
                dy = mem_y[i] - mem_y[j];
                sq = 64'(dx * dx) + 64'(dy * dy);
                r2 = longint'(sq >> 16) + cfg_blob;
                if (r2 == 0) continue;
                au = clampl(au - (dy * cfg_gamma) / r2, -SUM_LIM, SUM_LIM);
                av = clampl(av + (dx * cfg_gamma) / r2, -SUM_LIM, SUM_LIM);
            end
        end
        vel_x[i] = clampl(au, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        vel_y[i] = clampl(av, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    endfunction

    function automatic bit euler_step();
        int n;
        longint x, y, pull, d, off;
        bit spread;
        n = cfg_n > NPTS ? NPTS : int'(cfg_n);
        spread = 1'b0;
        for (int i = 0; i < n; i++) sum_velocity(i, n);
        for (int i = 0; i < n; i++) begin
            x = mem_x[i] + ((vel_x[i] * cfg_h) >>> 16);
            y = mem_y[i];
            pull = (cfg_rate * (y - cfg_mid)) >>> 16;
            d = clampl(vel_y[i] - pull, -HOP_LIM, HOP_LIM);
            if (cfg_period > 0) begin
                x = x % cfg_period;
                if (x < 0) x = x + cfg_period;
            end else begin
                x = clampl(x, POS_LO, POS_HI);
            end
            mem_x[i] = x;
            mem_y[i] = clampl(y + ((d * cfg_h) >>> 16), POS_LO, POS_HI);
        end
        for (int i = 0; i < n; i++) begin
            off = mem_y[i] - cfg_mid;
            if (off < 0) off = -off;
            if (off > cfg_spread) spread = 1'b1;
        end
        return spread;
    endfunction

    function automatic t_vortex_result apply_item(t_vortex_item it);
        t_vortex_result r;
        r = '{px: '0, py: '0, flag: 1'b0};
        if (it.op == vse_pkg::FUNC_STEP) begin
            r.flag = euler_step();
        end else if (it.op == vse_pkg::FUNC_LOAD || it.op == vse_pkg::FUNC_READ) begin
            if (it.op == vse_pkg::FUNC_LOAD) begin
                mem_x[it.idx] = longint'($signed(it.lx));
                mem_y[it.idx] = longint'($signed(it.ly));
            end
            r.px = mem_x[it.idx][27:0];
            r.py = mem_y[it.idx][27:0];
        end
        return r;
    endfunction

    // driver: acceptance predicts the result, then the next item or a gap is set up
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) expected_results.push_back(apply_item(cur_item));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.op;
                    s_tdata  <= {7'd0, cur_item.ly, cur_item.lx, cur_item.idx};
                    if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor with random back-pressure, none while quiet
    always @(posedge i_clk) begin
        t_vortex_result exp_r;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("vortex_sheet_euler_step regression: fail");
            $finish;
        end
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[27:0] !== exp_r.px) begin
                        $error("pos_x expected %h actual %h", exp_r.px, m_tdata[27:0]);
                        fail_count++;
                    end
                    if (m_tdata[55:28] !== exp_r.py) begin
                        $error("pos_y expected %h actual %h", exp_r.py, m_tdata[55:28]);
                        fail_count++;
                    end
                    if (m_tdata[56] !== exp_r.flag) begin
                        $error("spread_flag expected %b actual %b", exp_r.flag, m_tdata[56]);
                        fail_count++;
                    end
                end
            end
            if (quiet) begin
                m_tready <= 1'b1;
            end else if (recv_stall > 0) begin
                m_tready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else if ($urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                recv_stall <= $urandom_range(0, 4);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(logic [2:0] index, longint value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vse_pkg::PADDR_W'({index, 2'b00});
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            vse_pkg::REG_N_POINTS:     cfg_n      = value & 10'h3ff;
            vse_pkg::REG_GAMMA:        cfg_gamma  = value & 27'h7ffffff;
            vse_pkg::REG_BLOB_SQ:      cfg_blob   = value & 27'h7ffffff;
            vse_pkg::REG_PERIOD_WIDTH: cfg_period = value & 27'h7ffffff;
            vse_pkg::REG_MID_ROW:      cfg_mid    = value & 27'h7ffffff;
            vse_pkg::REG_PULL_RATE:    cfg_rate   = value & 20'hfffff;
            vse_pkg::REG_STEP_H:       cfg_h      = value & 17'h1ffff;
            default:                   cfg_spread = value & 27'h7ffffff;
        endcase
    endtask

    task automatic set_regs(longint n, longint g, longint b, longint w, longint m,
                            longint r, longint h, longint s);
        reg_write(vse_pkg::REG_N_POINTS, n);
        reg_write(vse_pkg::REG_GAMMA, g);
        reg_write(vse_pkg::REG_BLOB_SQ, b);
        reg_write(vse_pkg::REG_PERIOD_WIDTH, w);
        reg_write(vse_pkg::REG_MID_ROW, m);
        reg_write(vse_pkg::REG_PULL_RATE, r);
        reg_write(vse_pkg::REG_STEP_H, h);
        reg_write(vse_pkg::REG_SPREAD_LIMIT, s);
    endtask

    function automatic logic [27:0] pick_pos();
        case ($urandom_range(0, 3))
            0: return 28'($urandom);
            1: return 28'($urandom_range(0, 5242880));
            2: return 28'(-longint'($urandom_range(0, 2000000)));
            default: return 28'($urandom_range(0, 1572864));
        endcase
    endfunction

    task automatic queue_item(logic [1:0] op, int idx, logic [27:0] lx, logic [27:0] ly);
        pending_items.push_back('{op: op, idx: 9'(idx), lx: lx, ly: ly});
        if (op == vse_pkg::FUNC_LOAD && !loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    // steps only when steps_ok is set; callers clear it where the count would make the pairwise pass long
    task automatic queue_random(int count, bit steps_ok);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                queue_item(vse_pkg::FUNC_LOAD, ($urandom_range(0, 3) == 0)
                           ? $urandom_range(0, 511) : $urandom_range(0, STEP_MAX_N - 1),
                           pick_pos(), pick_pos());
            end else if (k < 70) begin
                queue_item(vse_pkg::FUNC_READ,
                           loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                           28'($urandom), 28'($urandom));
            end else if (k < 90 && steps_ok) begin
                queue_item(vse_pkg::FUNC_STEP, $urandom_range(0, 511), 28'($urandom),
                           28'($urandom));
            end else begin
                queue_item(vse_pkg::FUNC_NOP, $urandom_range(0, 511), 28'($urandom),
                           28'($urandom));
            end
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        cfg_n = 260; cfg_gamma = 38515; cfg_blob = 94372; cfg_period = 5242880;
        cfg_mid = 786432; cfg_rate = 26214; cfg_h = 546; cfg_spread = 1415578;
        foreach (mem_x[i]) begin
            mem_x[i] = 0; mem_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0; loaded[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill the stepping points, field extremes, every operation
        set_regs(4, 38515, 94372, 5242880, 786432, 26214, 546, 1415578);
        queue_item(vse_pkg::FUNC_LOAD, 0, 28'h8000000, 28'h7ffffff);
        queue_item(vse_pkg::FUNC_LOAD, 1, 28'h7ffffff, 28'h8000000);
        for (int i = 2; i < STEP_MAX_N; i++)
            queue_item(vse_pkg::FUNC_LOAD, i, 28'($urandom_range(0, 5242880)),
                       28'($urandom_range(500000, 1100000)));
        queue_item(vse_pkg::FUNC_LOAD, 511, 28'hfffffff, 28'h0000000);
        queue_item(vse_pkg::FUNC_READ, 511, 28'hfffffff, 28'hfffffff);
        queue_item(vse_pkg::FUNC_READ, 0, '0, '0);
        queue_item(vse_pkg::FUNC_NOP, 511, 28'hfffffff, 28'hfffffff);
        queue_item(vse_pkg::FUNC_STEP, 0, '0, '0);
        queue_item(vse_pkg::FUNC_LOAD, 0, 28'd65536, 28'd786432);
        queue_item(vse_pkg::FUNC_LOAD, 1, 28'd65536, 28'd786432);
        queue_item(vse_pkg::FUNC_STEP, 0, '0, '0);
        queue_item(vse_pkg::FUNC_READ, 0, '0, '0);
        queue_item(vse_pkg::FUNC_READ, 1, '0, '0);
        drain();

        // zero softening with coincident points, strength 2^26 and a unit step
        set_regs(8, 67108864, 0, 65536, 0, 655360, 65536, 0);
        queue_item(vse_pkg::FUNC_STEP, 0, '0, '0);
        queue_random(20, 1'b1);
        drain();

        // no points in use
        set_regs(0, 0, 67108864, 67108864, 67108864, 0, 0, 134217727);
        queue_item(vse_pkg::FUNC_STEP, 0, '0, '0);
        queue_random(15, 1'b1);
        drain();

        // count above the store depth, zero period; loads, reads and no-ops, no steps
        set_regs(1023, 12345, 1000, 0, 786432, 26214, 546, 1415578);
        queue_random(15, 1'b0);
        drain();

        // zero period with stepping
        set_regs(3, $urandom_range(0, 67108864), $urandom_range(0, 67108864), 0,
                 $urandom_range(0, 67108864), $urandom_range(0, 655360),
                 $urandom_range(0, 65536), $urandom_range(0, 134217727));
        queue_random(20, 1'b1);
        drain();

        // random settings, no idling to finish
        quiet = 1'b1;
        set_regs($urandom_range(1, STEP_MAX_N), $urandom_range(0, 67108864),
                 $urandom_range(0, 67108864), $urandom_range(65536, 67108864),
                 $urandom_range(0, 67108864), $urandom_range(0, 655360),
                 $urandom_range(0, 65536), $urandom_range(0, 134217727));
        queue_random(25, 1'b1);
        drain();

        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("vortex_sheet_euler_step regression: pass");
        end else begin
            $display("vortex_sheet_euler_step regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vse_pkg.sv
hw/rtl/vse_cfg.sv
hw/rtl/vse_div.sv
hw/rtl/vortex_sheet_euler_step.sv
verif/tb_vortex_sheet_euler_step.sv
